// ----- src/sirgen_pkg.sv -----
package sirgen_pkg;

    // field widths of the configuration registers
    localparam int SR_W       = 18;
    localparam int FREQ_W     = 15;
    localparam int AMP_W      = 15;
    localparam int BLEN_W     = 11;
    localparam int DUR_W      = 10;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;

    // result and state widths
    localparam int SMP_W = 16;
    localparam int SIB_W = 10;
    localparam int PER_W = 18;
    localparam int BC_W  = DUR_W + PER_W;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION_S  = 3'd5;

    localparam logic [BLEN_W-1:0] BLEN_MAX = 11'd1024;

    // sine table construction constants, q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    typedef struct packed {
        logic [SR_W-1:0]   sample_rate;
        logic [FREQ_W-1:0] freq_low;
        logic [FREQ_W-1:0] freq_high;
        logic [AMP_W-1:0]  amplitude;
        logic [BLEN_W-1:0] block_len;
        logic [DUR_W-1:0]  duration_s;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        sample_rate: 18'd44100,
        freq_low:    15'd600,
        freq_high:   15'd1200,
        amplitude:   15'd16000,
        block_len:   11'd32,
        duration_s:  10'd3
    };

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    last_in_block;
        logic                    siren_done;
        logic                    active;
    } res_t;

endpackage

// ----- src/sirgen_front.sv -----
module sirgen_front (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic restart,
    output logic q_valid,
    output logic q_restart,
    input  logic q_pop
);

    localparam int DEPTH = sirgen_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign q_valid   = (cnt_reg != '0);
    assign q_restart = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // item payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= restart;
        end
    end

endmodule

// ----- src/sirgen_div.sv -----
module sirgen_div #(
    parameter int DVD_W = 47,
    parameter int DVS_W = 18
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

endmodule

// ----- src/sirgen_back.sv -----
module sirgen_back #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sirgen_pkg::cfg_t  cfg,
    input  logic              cfg_wr,
    input  logic              q_valid,
    input  logic              q_restart,
    output logic              q_pop,
    input  logic              res_ready,
    output logic              res_push,
    output sirgen_pkg::res_t  res
);

    localparam int LOG2D   = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER = SINE_TABLE_DEPTH / 4;
    localparam int ADDR_W  = LOG2D - 1;
    localparam int ENT_W   = 16;
    localparam int AP_W    = sirgen_pkg::AMP_W + ENT_W;
    localparam int MAG_SH  = 15;
    localparam int FREQ_W  = sirgen_pkg::FREQ_W;
    localparam int PER_W   = sirgen_pkg::PER_W;
    localparam int BC_W    = sirgen_pkg::BC_W;
    localparam int SIB_W   = sirgen_pkg::SIB_W;
    localparam int BLEN_W  = sirgen_pkg::BLEN_W;
    localparam int AMP_W   = sirgen_pkg::AMP_W;
    localparam int SMP_W   = sirgen_pkg::SMP_W;
    localparam int PROD_W  = FREQ_W + 1 + PER_W + 1;
    localparam int MAG_W   = PROD_W - 1;
    localparam int DVD_W   = (PHASE_BITS + FREQ_W > MAG_W) ? PHASE_BITS + FREQ_W : MAG_W;
    localparam int DVS_W   = PER_W;
    localparam int FS_W    = FREQ_W + 2;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE = 4'd0;
    localparam logic [ST_W-1:0] S_PDIV = 4'd1;
    localparam logic [ST_W-1:0] S_PMUL = 4'd2;
    localparam logic [ST_W-1:0] S_LOOK = 4'd3;
    localparam logic [ST_W-1:0] S_MUL  = 4'd4;
    localparam logic [ST_W-1:0] S_MDIV = 4'd5;
    localparam logic [ST_W-1:0] S_FMUL = 4'd6;
    localparam logic [ST_W-1:0] S_FABS = 4'd7;
    localparam logic [ST_W-1:0] S_FDIV = 4'd8;
    localparam logic [ST_W-1:0] S_FSUM = 4'd9;
    localparam logic [ST_W-1:0] S_SDIV = 4'd10;
    localparam logic [ST_W-1:0] S_OUT  = 4'd11;

    // quarter-wave entry k in q15, evaluated at elaboration only
    function automatic logic [ENT_W-1:0] quarter_sine(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = (longint'(k) * sirgen_pkg::HALF_PI_Q30) / QUARTER;
        x2 = (x * x) >> 30;
        t  = sirgen_pkg::ONE_Q30;
        t  = sirgen_pkg::ONE_Q30 - (((x2 * t) >> 30) / 110);
        t  = sirgen_pkg::ONE_Q30 - (((x2 * t) >> 30) / 72);
        t  = sirgen_pkg::ONE_Q30 - (((x2 * t) >> 30) / 42);
        t  = sirgen_pkg::ONE_Q30 - (((x2 * t) >> 30) / 20);
        t  = sirgen_pkg::ONE_Q30 - (((x2 * t) >> 30) / 6);
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32768)
        begin
            s = 64'd32768;
        end
        return s[ENT_W-1:0];
    endfunction

    logic [ENT_W-1:0] qtab [QUARTER+1];

    for (genvar k = 0; k <= QUARTER; k++)
    begin : g_qtab
        assign qtab[k] = quarter_sine(k);
    end

    // control state
    logic [ST_W-1:0]       state_reg, state_next;
    logic                  stale_reg, stale_next;
    logic                  running_reg, running_next;
    logic [BC_W-1:0]       bc_reg, bc_next;
    logic [SIB_W-1:0]      sib_reg, sib_next;
    logic [PHASE_BITS-1:0] ph_reg, ph_next;
    logic [PHASE_BITS-1:0] step_reg, step_next;
    logic                  ph_pend_reg, ph_pend_next;
    logic                  need_reg, need_next;

    // working registers
    logic [PER_W-1:0]         per_reg, per_next;
    logic [BC_W-1:0]          tot_reg, tot_next;
    logic [ENT_W-1:0]         ent_reg, ent_next;
    logic                     neg_reg, neg_next;
    logic                     last_reg, last_next;
    logic                     sdone_reg, sdone_next;
    logic                     act_reg, act_next;
    logic [AMP_W-1:0]         mag_reg, mag_next;
    logic signed [FREQ_W:0]   diff_reg, diff_next;
    logic [PER_W-1:0]         mm_reg, mm_next;
    logic                     lowh_reg, lowh_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [FREQ_W-1:0]        f_reg, f_next;

    // shared divider
    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic [DVS_W-1:0] div_rem;

    sirgen_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // combinational helpers
    logic [BLEN_W-1:0]     ebl;
    logic [PER_W-1:0]      half;
    logic                  rs, run_a, last_a, done_a;
    logic [BC_W-1:0]       bc_a;
    logic [SIB_W-1:0]      sib_a;
    logic [PHASE_BITS-1:0] ph_a;
    logic [LOG2D-1:0]      idx;
    logic [1:0]            quad;
    logic [ADDR_W-2:0]     rr;
    logic [ADDR_W-1:0]     addr;
    logic [AP_W-1:0]       amp_prod;
    logic                  pneg;
    logic [PROD_W-1:0]     pabs;
    logic signed [FS_W-1:0] sq, fsum;

    always_comb
    begin
        priority if (cfg.block_len == '0)
        begin
            ebl = BLEN_W'(1);
        end
        else if (cfg.block_len > sirgen_pkg::BLEN_MAX)
        begin
            ebl = sirgen_pkg::BLEN_MAX;
        end
        else
        begin
            ebl = cfg.block_len;
        end
    end

    assign half = per_reg >> 1;

    // restart applied ahead of the sample
    assign rs     = q_restart;
    assign run_a  = rs ? (tot_reg != '0) : running_reg;
    assign bc_a   = rs ? '0 : bc_reg;
    assign sib_a  = rs ? '0 : sib_reg;
    assign ph_a   = rs ? '0 : ph_reg;
    assign last_a = (({1'b0, sib_a} + 1'b1) >= ebl);
    assign done_a = last_a && (({1'b0, bc_a} + 1'b1) >= {1'b0, tot_reg});

    // table address with quarter-wave mirroring
    assign idx  = ph_a[PHASE_BITS-1 -: LOG2D];
    assign quad = idx[LOG2D-1 -: 2];
    assign rr   = idx[LOG2D-3:0];
    assign addr = quad[0] ? (ADDR_W'(QUARTER) - ADDR_W'(rr)) : ADDR_W'(rr);

    assign amp_prod = AP_W'(cfg.amplitude) * AP_W'(ent_reg);

    assign pneg = prod_reg[PROD_W-1];
    assign pabs = pneg ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign sq   = pneg ? -$signed(FS_W'(div_quo[FREQ_W-1:0]))
                       : $signed(FS_W'(div_quo[FREQ_W-1:0]));
    assign fsum = lowh_reg ? $signed(FS_W'(cfg.freq_low)) + sq
                           : $signed(FS_W'(cfg.freq_high)) - sq;

    always_comb
    begin
        state_next   = state_reg;
        stale_next   = stale_reg;
        running_next = running_reg;
        bc_next      = bc_reg;
        sib_next     = sib_reg;
        ph_next      = ph_reg;
        step_next    = step_reg;
        ph_pend_next = ph_pend_reg;
        need_next    = need_reg;
        per_next     = per_reg;
        tot_next     = tot_reg;
        ent_next     = ent_reg;
        neg_next     = neg_reg;
        last_next    = last_reg;
        sdone_next   = sdone_reg;
        act_next     = act_reg;
        mag_next     = mag_reg;
        diff_next    = diff_reg;
        mm_next      = mm_reg;
        lowh_next    = lowh_reg;
        prod_next    = prod_reg;
        f_next       = f_reg;
        div_start    = 1'b0;
        div_dvd      = '0;
        div_dvs      = '0;
        q_pop        = 1'b0;
        res_push     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (stale_reg)
                    begin
                        div_start  = 1'b1;
                        div_dvd    = DVD_W'(cfg.sample_rate);
                        div_dvs    = DVS_W'(ebl);
                        state_next = S_PDIV;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_PDIV:
            begin
                if (div_done)
                begin
                    // sweep period, never below two blocks
                    per_next   = (div_quo < DVD_W'(2)) ? PER_W'(2) : div_quo[PER_W-1:0];
                    state_next = S_PMUL;
                end
            end
            S_PMUL:
            begin
                tot_next   = BC_W'(cfg.duration_s) * BC_W'(per_reg);
                stale_next = 1'b0;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                q_pop      = 1'b1;
                ent_next   = run_a ? qtab[addr] : '0;
                neg_next   = quad[1];
                last_next  = run_a && last_a;
                sdone_next = run_a && done_a;
                act_next   = run_a;
                bc_next    = bc_a;
                sib_next   = sib_a;
                ph_next    = ph_a;
                running_next = run_a;
                ph_pend_next = 1'b0;
                if (run_a)
                begin
                    if (last_a)
                    begin
                        sib_next     = '0;
                        ph_next      = '0;
                        bc_next      = bc_a + 1'b1;
                        running_next = !done_a;
                    end
                    else
                    begin
                        sib_next = sib_a + 1'b1;
                        if (rs)
                        begin
                            // phase waits for the step of block zero
                            ph_pend_next = 1'b1;
                        end
                        else
                        begin
                            ph_next = ph_a + step_reg;
                        end
                    end
                end
                need_next  = run_a && !(last_a && done_a) && (rs || last_a);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                mag_next = amp_prod[MAG_SH +: AMP_W];
                if (need_reg)
                begin
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'(bc_reg);
                    div_dvs    = per_reg;
                    state_next = S_MDIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_MDIV:
            begin
                if (div_done)
                begin
                    // rising half or falling half of the sweep
                    if (div_rem < half)
                    begin
                        mm_next   = div_rem;
                        lowh_next = 1'b1;
                    end
                    else
                    begin
                        mm_next   = div_rem - half;
                        lowh_next = 1'b0;
                    end
                    diff_next  = $signed({1'b0, cfg.freq_high}) - $signed({1'b0, cfg.freq_low});
                    state_next = S_FMUL;
                end
            end
            S_FMUL:
            begin
                prod_next  = PROD_W'(diff_reg) * PROD_W'($signed({1'b0, mm_reg}));
                state_next = S_FABS;
            end
            S_FABS:
            begin
                div_start  = 1'b1;
                div_dvd    = DVD_W'(pabs[MAG_W-1:0]);
                div_dvs    = half;
                state_next = S_FDIV;
            end
            S_FDIV:
            begin
                if (div_done)
                begin
                    f_next     = fsum[FS_W-1] ? '0 : fsum[FREQ_W-1:0];
                    state_next = S_FSUM;
                end
            end
            S_FSUM:
            begin
                if (cfg.sample_rate == '0)
                begin
                    step_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'({f_reg, {PHASE_BITS{1'b0}}});
                    div_dvs    = cfg.sample_rate;
                    state_next = S_SDIV;
                end
            end
            S_SDIV:
            begin
                if (div_done)
                begin
                    step_next = div_quo[PHASE_BITS-1:0];
                    if (ph_pend_reg)
                    begin
                        ph_next = div_quo[PHASE_BITS-1:0];
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    res_push     = 1'b1;
                    ph_pend_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            stale_next = 1'b1;
        end
    end

    always_comb
    begin
        res.sample        = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
        res.last_in_block = last_reg;
        res.siren_done    = sdone_reg;
        res.active        = act_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            stale_reg   <= 1'b1;
            running_reg <= 1'b0;
            bc_reg      <= '0;
            sib_reg     <= '0;
            ph_reg      <= '0;
            step_reg    <= '0;
            ph_pend_reg <= 1'b0;
            need_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            stale_reg   <= stale_next;
            running_reg <= running_next;
            bc_reg      <= bc_next;
            sib_reg     <= sib_next;
            ph_reg      <= ph_next;
            step_reg    <= step_next;
            ph_pend_reg <= ph_pend_next;
            need_reg    <= need_next;
        end
    end

    always_ff @(posedge clk)
    begin
        per_reg   <= per_next;
        tot_reg   <= tot_next;
        ent_reg   <= ent_next;
        neg_reg   <= neg_next;
        last_reg  <= last_next;
        sdone_reg <= sdone_next;
        act_reg   <= act_next;
        mag_reg   <= mag_next;
        diff_reg  <= diff_next;
        mm_reg    <= mm_next;
        lowh_reg  <= lowh_next;
        prod_reg  <= prod_next;
        f_reg     <= f_next;
    end

endmodule

// ----- src/siren_tone_generator.sv -----
// swept-sine siren: every accepted item is one sample tick and returns one signed
// 16-bit sample. the frequency steps once per block of block_len samples, rising
// from freq_low to freq_high over half a sweep period and falling back, and the
// sine restarts at phase zero with every block. an item with restart set starts
// a new siren at block zero; outside a siren the samples are zero with active low.
// a plain sample passes through queue pop, quarter-wave table read, amplitude
// multiply and output register. a sample that ends a block, but not the siren,
// or restarts the siren also computes the next phase step in up to three passes
// of the shared one-bit-per-cycle divider, whose dividend is DVD_W bits wide,
// where DVD_W is max(PHASE_BITS+15, 34). the first item after any register
// write adds one more divider pass to recompute the sweep period. the divider
// sets the block-end time. a two-entry input queue and the output register let
// the source and the sink stall independently. the user must write registers
// only while no item is in flight; the block itself does not enforce this.
module siren_tone_generator #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [sirgen_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sirgen_pkg::CFG_DATA_W-1:0]   cfg_data,
    // tick items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    // sample items
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [sirgen_pkg::SMP_W-1:0] sample,
    output logic                                last_in_block,
    output logic                                siren_done,
    output logic                                active
);

    // configuration registers
    sirgen_pkg::cfg_t cfg_reg, cfg_next;

    // front to back queue
    logic q_valid;
    logic q_restart;
    logic q_pop;

    // back to output register
    logic             res_push;
    logic             slot_free;
    sirgen_pkg::res_t res;

    // output register
    logic             out_valid_reg, out_valid_next;
    sirgen_pkg::res_t res_reg;

    // register write decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                sirgen_pkg::CFG_SAMPLE_RATE:
                begin
                    cfg_next.sample_rate = cfg_data[sirgen_pkg::SR_W-1:0];
                end
                sirgen_pkg::CFG_FREQ_LOW:
                begin
                    cfg_next.freq_low = cfg_data[sirgen_pkg::FREQ_W-1:0];
                end
                sirgen_pkg::CFG_FREQ_HIGH:
                begin
                    cfg_next.freq_high = cfg_data[sirgen_pkg::FREQ_W-1:0];
                end
                sirgen_pkg::CFG_AMPLITUDE:
                begin
                    cfg_next.amplitude = cfg_data[sirgen_pkg::AMP_W-1:0];
                end
                sirgen_pkg::CFG_BLOCK_LEN:
                begin
                    cfg_next.block_len = cfg_data[sirgen_pkg::BLEN_W-1:0];
                end
                sirgen_pkg::CFG_DURATION_S:
                begin
                    cfg_next.duration_s = cfg_data[sirgen_pkg::DUR_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= sirgen_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accepts ticks into the queue
    sirgen_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .q_valid   (q_valid),
        .q_restart (q_restart),
        .q_pop     (q_pop)
    );

    // back: siren state, sine lookup and step computation
    sirgen_back #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_wr    (cfg_we),
        .q_valid   (q_valid),
        .q_restart (q_restart),
        .q_pop     (q_pop),
        .res_ready (slot_free),
        .res_push  (res_push),
        .res       (res)
    );

    // output register, refilled in the cycle it drains
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample        = res_reg.sample;
    assign last_in_block = res_reg.last_in_block;
    assign siren_done    = res_reg.siren_done;
    assign active        = res_reg.active;

    // the end of a siren always closes a block of a sounding siren
    a_done_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && siren_done |-> last_in_block && active)
        else $error("siren_done without last_in_block or active");

    // idle samples carry nothing
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active |-> sample == '0 && !last_in_block && !siren_done)
        else $error("idle sample is not all zero");

    // back never overwrites a sample still waiting at the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !out_valid_reg || out_ready)
        else $error("output register overwritten while stalled");

endmodule
